FILE: rtl/bal_pkg.sv
// Package for the bounded array list: request codes, status codes,
// controller states and the controller-to-datapath command bundle.
// No dependencies.
package bal_pkg;

  localparam int unsigned DEF_CAPACITY  = 16;
  localparam int unsigned DEF_WORD_BITS = 32;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned IO_WORD_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_GET    = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    REQ_EMPTY,
    REQ_PENDING
  } req_state_e;

  typedef struct packed {
    logic load_req;
    logic exec;
  } bal_cmd_t;

endpackage

FILE: rtl/bal_ctrl.sv
// Controller of the bounded array list: request slot state machine and
// result valid flag, issuing load and execute commands to the datapath.
// Depends on bal_pkg.
module bal_ctrl
  import bal_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  output logic     m_tvalid_o,
  input  logic     m_tready_i,
  output bal_cmd_t cmd_o
);

  req_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= REQ_EMPTY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o.exec     = 1'b0;
    cmd_o.load_req = 1'b0;
    s_tready_o     = 1'b0;
    state_d        = state_q;
    case (state_q)
      REQ_EMPTY: begin
        s_tready_o = 1'b1;
      end
      REQ_PENDING: begin
        cmd_o.exec = !out_valid_q || m_tready_i;
        s_tready_o = cmd_o.exec;
      end
      default: begin
        state_d = REQ_EMPTY;
      end
    endcase
    cmd_o.load_req = s_tvalid_i && s_tready_o;
    if (cmd_o.load_req) begin
      state_d = REQ_PENDING;
    end else if (cmd_o.exec) begin
      state_d = REQ_EMPTY;
    end
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_tvalid_o = out_valid_q;

  // a waiting result must not be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_tready_i) |-> !cmd_o.exec)
    else $error("result overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |=> (state_q == REQ_PENDING))
    else $error("accepted request lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == REQ_PENDING && !cmd_o.exec) |=> (state_q == REQ_PENDING))
    else $error("pending request dropped without execution");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_q)
    else $error("executed request gave no result");

endmodule

FILE: rtl/bal_datapath.sv
// Datapath of the bounded array list: request register, chain of entry
// cells with parallel shift, fill count and result register.
// Depends on bal_pkg.
module bal_datapath
  import bal_pkg::*;
#(
  parameter int unsigned CAPACITY  = DEF_CAPACITY,
  parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bal_cmd_t             cmd_i,
  input  logic [OPCODE_W-1:0]  opcode_i,
  input  logic [POS_W-1:0]     position_i,
  input  logic [IO_WORD_W-1:0] word_in_i,
  output logic [IO_WORD_W-1:0] word_out_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [COUNT_W-1:0]   entry_count_o,
  output logic                 full_flag_o,
  output logic                 empty_flag_o
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned EXT_W  = (WORD_BITS > IO_WORD_W) ? WORD_BITS : IO_WORD_W;
  localparam int unsigned EXTC_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [OPCODE_W-1:0]  req_op_q;
  logic [POS_W-1:0]     req_pos_q;
  logic [WORD_BITS-1:0] req_word_q;
  logic [EXT_W-1:0]     word_in_ext;

  logic [WORD_BITS-1:0] cell_q [CAPACITY];
  logic [WORD_BITS-1:0] cell_d [CAPACITY];
  logic [CNT_W-1:0]     count_q, count_d;

  logic [IO_WORD_W-1:0] word_out_q;
  logic [STATUS_W-1:0]  status_q;
  logic [COUNT_W-1:0]   count_out_q;
  logic                 full_out_q, empty_out_q;

  logic [CMP_W-1:0]     pos_c, cnt_c;
  logic                 is_full, pos_lt_cnt, pos_ge_cap;
  logic                 do_push, do_ins, do_rem, do_get;
  status_e              status_d;
  logic [WORD_BITS-1:0] rd_word;
  logic [EXT_W-1:0]     rd_ext;
  logic [EXTC_W-1:0]    count_ext;

  assign word_in_ext = EXT_W'(word_in_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_op_q   <= opcode_i;
      req_pos_q  <= position_i;
      req_word_q <= word_in_ext[WORD_BITS-1:0];
    end
  end

  assign pos_c      = CMP_W'(req_pos_q);
  assign cnt_c      = CMP_W'(count_q);
  assign is_full    = (count_q == CNT_W'(CAPACITY));
  assign pos_lt_cnt = (pos_c < cnt_c);
  assign pos_ge_cap = (pos_c >= CMP_W'(CAPACITY));

  always_comb begin
    do_push  = 1'b0;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_get   = 1'b0;
    status_d = ST_OK;
    count_d  = count_q;
    case (req_op_q)
      OP_PUSH: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          do_push = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_POP: begin
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos_ge_cap) begin
          status_d = ST_RANGE;
        end else if (is_full) begin
          status_d = ST_FULL;
        end else if (!pos_lt_cnt) begin
          status_d = ST_RANGE;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!pos_lt_cnt) begin
          status_d = ST_RANGE;
        end else begin
          do_rem  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      OP_GET: begin
        if (!pos_lt_cnt) begin
          status_d = ST_RANGE;
        end else begin
          do_get = 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // each cell sees only its neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] lower_w, upper_w;
    logic [CMP_W-1:0]     idx_w, idx_nx_w;
    if (i > 0) begin : g_lo
      assign lower_w = cell_q[i-1];
    end else begin : g_lo0
      assign lower_w = cell_q[i];
    end
    if (i < CAPACITY - 1) begin : g_hi
      assign upper_w = cell_q[i+1];
    end else begin : g_hi_last
      assign upper_w = cell_q[i];
    end
    assign idx_w    = CMP_W'(i);
    assign idx_nx_w = CMP_W'(i + 1);
    assign cell_d[i] =
      (do_push && idx_w == cnt_c)                    ? req_word_q :
      (do_ins && idx_w == pos_c)                     ? req_word_q :
      (do_ins && idx_w > pos_c && idx_w <= cnt_c)    ? lower_w    :
      (do_rem && idx_w >= pos_c && idx_nx_w < cnt_c) ? upper_w    :
                                                       cell_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      cell_q <= cell_d;
    end
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_get && pos_c == CMP_W'(i)) begin
        rd_word = cell_q[i];
      end
    end
  end

  assign rd_ext    = EXT_W'(rd_word);
  assign count_ext = EXTC_W'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      word_out_q  <= rd_ext[IO_WORD_W-1:0];
      status_q    <= status_d;
      count_out_q <= count_ext[COUNT_W-1:0];
      full_out_q  <= (count_d == CNT_W'(CAPACITY));
      empty_out_q <= (count_d == '0);
    end
  end

  assign word_out_o    = word_out_q;
  assign status_o      = status_q;
  assign entry_count_o = count_out_q;
  assign full_flag_o   = full_out_q;
  assign empty_flag_o  = empty_out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (do_push || do_ins)) |=> (count_q == $past(count_q) + 1'b1))
    else $error("append or insert did not grow the list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(count_q))
    else $error("fill count moved without a request");

endmodule

FILE: rtl/bounded_array_list_core.sv
// Bounded array list, top level: stream ports, request field unpacking and
// result packing around controller and datapath.
// Depends on bal_pkg, bal_ctrl and bal_datapath.
//
// Use: one request in on the s_ group gives exactly one result on the m_
// group. A request carries opcode (push, pop, insert, remove, get), a
// position and a word; the result carries the word read by get, a status
// (ok, list full, index out of range), the entry count after the request
// and full and empty flags.
// A request taken waits in the request register until the result register
// is free or being read; it is then executed, the result register loads and
// m_tvalid_o rises.
// Throughput: one request per cycle while the receiver does not stall.
// Entry cells all shift in parallel, so insert and remove need one execute.
// One request register and one result register sit between the sides: a
// new request is taken while a result waits. When the receiver stalls, the
// result holds, the pending request waits and s_tready_o drops.
// Reset clears the fill count and both valid flags; the list is empty and
// entry contents are undefined until written.
module bounded_array_list_core
  import bal_pkg::*;
#(
  parameter int unsigned CAPACITY  = DEF_CAPACITY,
  parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  // opcode [2:0], position [6:3], word_in [38:7], zero [39]
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  // word_out [31:0], status [33:32], entry_count [38:34],
  // full_flag [39], empty_flag [40], zero [47:41]
  output logic [M_TDATA_W-1:0] m_tdata_o
);

  bal_cmd_t             cmd;
  logic [IO_WORD_W-1:0] word_out;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   entry_count;
  logic                 full_flag, empty_flag;

  bal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cmd_o      (cmd)
  );

  bal_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .opcode_i      (s_tdata_i[2:0]),
    .position_i    (s_tdata_i[6:3]),
    .word_in_i     (s_tdata_i[38:7]),
    .word_out_o    (word_out),
    .status_o      (status),
    .entry_count_o (entry_count),
    .full_flag_o   (full_flag),
    .empty_flag_o  (empty_flag)
  );

  assign m_tdata_o = {7'd0, empty_flag, full_flag, entry_count, status, word_out};

endmodule

FILE: sim/tb_bounded_array_list_core.sv
// Testbench for bounded_array_list_core: list requests driven on the s_ stream
// with random gaps and stalls, results checked against an own list predictor.
// Depends on bal_pkg and the RTL of bounded_array_list_core.
`timescale 1ns / 100ps

module tb_bounded_array_list_core
  import bal_pkg::*;
();

  typedef struct packed {
    logic [IO_WORD_W-1:0] word_out;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   entry_count;
    logic                 full_flag;
    logic                 empty_flag;
  } list_result_t;

  class list_scoreboard;
    logic [IO_WORD_W-1:0] words [DEF_CAPACITY];
    int unsigned          fill;
    list_result_t         expected_q [$];
    int unsigned          errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string what, logic [IO_WORD_W-1:0] got, logic [IO_WORD_W-1:0] want);
      $display("mismatch: %s got %0h expected %0h", what, got, want);
      errors++;
    endtask

    // Apply one accepted request to the list copy and queue its result.
    function void note_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [IO_WORD_W-1:0] word);
      list_result_t r;
      r        = '0;
      r.status = ST_OK;
      case (op)
        OP_PUSH: begin
          if (fill >= DEF_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            words[fill] = word;
            fill++;
          end
        end
        OP_POP: begin
          if (fill > 0) fill--;
        end
        OP_INSERT: begin
          if (pos >= DEF_CAPACITY) begin
            r.status = ST_RANGE;
          end else if (fill >= DEF_CAPACITY) begin
            r.status = ST_FULL;
          end else if (pos >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int unsigned i = fill; i > pos; i--) words[i] = words[i-1];
            words[pos] = word;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (pos >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int unsigned i = pos; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        OP_GET: begin
          if (pos >= fill) r.status = ST_RANGE;
          else r.word_out = words[pos];
        end
        default: begin
        end
      endcase
      r.entry_count = fill[COUNT_W-1:0];
      r.full_flag   = (fill == DEF_CAPACITY);
      r.empty_flag  = (fill == 0);
      expected_q.push_back(r);
    endfunction

    task check_result(logic [M_TDATA_W-1:0] tdata);
      list_result_t got, want;
      got = {tdata[31:0], tdata[33:32], tdata[38:34], tdata[39], tdata[40]};
      if (expected_q.size() == 0) begin
        report("result with no request pending, word", got.word_out, '0);
      end else begin
        want = expected_q.pop_front();
        if (got.word_out !== want.word_out) report("word_out", got.word_out, want.word_out);
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.entry_count !== want.entry_count)
          report("entry_count", got.entry_count, want.entry_count);
        if (got.full_flag !== want.full_flag)
          report("full_flag", got.full_flag, want.full_flag);
        if (got.empty_flag !== want.empty_flag)
          report("empty_flag", got.empty_flag, want.empty_flag);
        if (tdata[M_TDATA_W-1:41] !== '0) report("pad bits", tdata[M_TDATA_W-1:41], '0);
      end
    endtask
  endclass

  localparam logic [OPCODE_W-1:0] OP_SPARE_BASE = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_TOP  = 3'd7;
  localparam int unsigned RANDOM_REQUESTS = 950;
  localparam int unsigned HOLD_CYCLES     = 60;
  localparam int unsigned DRAIN_LIMIT     = 5000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_tvalid_i;
  logic                 s_tready_o;
  logic [S_TDATA_W-1:0] s_tdata_i;
  logic                 m_tvalid_o;
  logic                 m_tready_i;
  logic [M_TDATA_W-1:0] m_tdata_o;

  logic hold_req;
  logic steady;

  list_scoreboard sb;

  bounded_array_list_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Offer one request from the next falling edge until it is taken.
  task send_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                    logic [IO_WORD_W-1:0] word);
    @(negedge clk_i);
    s_tvalid_i = 1'b1;
    s_tdata_i  = {1'b0, word, pos, op};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_request(op, pos, word);
  endtask

  task sender_idle(int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      s_tvalid_i = 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [OPCODE_W-1:0] pick_op(int unsigned mode);
    int unsigned r;
    int unsigned lim [5];
    r = $urandom_range(0, 99);
    case (mode)
      0: lim = '{35, 60, 80, 88, 95};
      1: lim = '{10, 18, 38, 68, 95};
      default: lim = '{20, 40, 60, 77, 95};
    endcase
    if (r < lim[0]) return OP_PUSH;
    if (r < lim[1]) return OP_INSERT;
    if (r < lim[2]) return OP_GET;
    if (r < lim[3]) return OP_REMOVE;
    if (r < lim[4]) return OP_POP;
    return OPCODE_W'($urandom_range(OP_SPARE_BASE, OP_SPARE_TOP));
  endfunction

  // Receiver: random stalls, steady stretches and a long hold-off on request.
  initial begin
    int unsigned held;
    int unsigned n;
    bit          hold_done;
    m_tready_i = 1'b0;
    hold_done  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_tready_i = 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk_i);
        hold_done  = 1'b1;
        m_tready_i = 1'b1;
      end else if (steady) begin
        m_tready_i = 1'b1;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          m_tready_i = 1'b0;
          repeat (n) @(negedge clk_i);
        end
        m_tready_i = 1'b1;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) sb.check_result(m_tdata_o);
  end

  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned wait_cycles;
    logic [POS_W-1:0] pos;
    sb         = new();
    rst_ni     = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    hold_req   = 1'b0;
    steady     = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty list, range edges, fill to full, full refusals
    send_request(OP_POP, '0, '0);
    send_request(OP_GET, '0, '0);
    send_request(OP_INSERT, '0, 32'h1234_5678);
    send_request(OP_PUSH, '0, '1);
    send_request(OP_INSERT, 4'd1, 32'hDEAD_BEEF);
    send_request(OP_INSERT, '0, 32'h5A5A_5A5A);
    for (int i = 0; i < 14; i++) begin
      send_request(OP_PUSH, '1, (i % 2 == 0) ? 32'h0 : $urandom);
    end
    send_request(OP_PUSH, '0, 32'hA5A5_A5A5);
    send_request(OP_INSERT, '1, 32'hCAFE_F00D);
    send_request(OP_GET, '1, '0);
    send_request(OP_REMOVE, '0, '0);
    send_request(OP_SPARE_TOP, '1, '1);

    mode      = 2;
    mode_left = 0;
    for (int unsigned k = 0; k < RANDOM_REQUESTS; k++) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 90);
      end
      mode_left--;
      steady = (k >= 100 && k < 200);
      if (k == 350) hold_req = 1'b1;
      if (k == 650) begin
        sender_idle(1);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      if (sb.fill > 0 && $urandom_range(0, 9) < 8) begin
        pos = POS_W'($urandom_range(0, sb.fill - 1));
      end else begin
        pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
      end
      if (!steady) sender_idle(pick_gap());
      send_request(pick_op(mode), pos, $urandom);
    end
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    steady     = 1'b0;

    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("requests left without result", sb.pending(), '0);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
